// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the histogram statistics core
// Clocked property checks; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define HSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HSC_ASSERT(label, clk, rst, prop)
`define HSC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/hsc_pkg.sv
// ---------------------------------------------------------------------------
// hsc_pkg
// Types, widths and codes shared by the histogram statistics core.
// ---------------------------------------------------------------------------
package hsc_pkg;

  localparam int BIN_COUNT_DEF   = 4096;
  localparam int COUNT_WIDTH_DEF = 32;

  // internal arithmetic widths, sized for the largest bin count
  localparam int CNT_ACC_W  = 48;
  localparam int SUM_W      = 64;
  localparam int DEV_W      = 24;
  localparam int SQ_W       = 48;
  localparam int MUL1_W     = 56;
  localparam int ACC_W      = 96;
  localparam int DIV_NUM_W  = 96;
  localparam int DIV_DEN_W  = 56;
  localparam int DIV_Q_W    = 32;
  localparam int ORG_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIV_Q_W-1:0] MEAN_CAP = 32'h000F_FFFF;
  localparam logic [DIV_Q_W-1:0] VAR_CAP  = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_BEGIN      = 3'd0,
    CFG_RANGE_END        = 3'd1,
    CFG_SEARCH_ORIGIN    = 3'd2,
    CFG_ORIGIN_FROM_MEAN = 3'd3,
    CFG_RUN_LENGTH       = 3'd4,
    CFG_BIN_THRESHOLD    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_STAT = 2'd0,
    OP_VAR  = 2'd1,
    OP_DOWN = 2'd2,
    OP_UP   = 2'd3
  } op_t;

  typedef struct packed {
    logic [11:0] range_begin;
    logic [12:0] range_end;
    logic [11:0] search_origin;
    logic        origin_from_mean;
    logic [11:0] run_length;
    logic [31:0] bin_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0] strip_number;
    logic [31:0] bin_count;
    logic        is_last;
  } bin_item_t;

  typedef struct packed {
    logic [15:0] strip_id_out;
    logic [43:0] total_count;
    logic [55:0] weighted_sum;
    logic [19:0] mean_value;
    logic [30:0] variance_value;
    logic        empty_flag;
    logic [11:0] lower_cutoff;
    logic [11:0] upper_cutoff_end;
    logic [11:0] upper_cutoff_before;
    logic        lower_found;
    logic        upper_found;
  } result_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_open;
    logic op_start;
    op_t  op;
    logic div_start;
    logic div_var;
    logic out_load;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_in;
    logic op_done;
    logic div_done;
    logic empty;
    logic out_free;
    logic busy;
  } sts_t;

endpackage

// File: rtl/histogram_stats_and_cutoff_core.sv
// Takes one histogram as a stream of bin counts (bin 0 first, one bin per cycle while
// bin_stall is low) and, after the bin marked last, returns one result: count, weighted
// sum, mean (12.8), variance (23.8) over the configured range, plus downward and upward
// cutoff searches for a run of low bins. After the last bin the block stalls its input
// through the statistics pass, the bit-serial mean division, the variance pass, the
// bit-serial variance division and the two searches; an empty range skips the variance
// pass and both divisions, and a result still waiting at the output adds its wait. The
// single read port of the bin store sets the sweep lengths. Unsent bins read as zero
// through the fill count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// histogram_stats_and_cutoff_core
// Top level: configuration registers, sequencer and datapath.
// ---------------------------------------------------------------------------
module histogram_stats_and_cutoff_core #(
  parameter int BIN_COUNT   = hsc_pkg::BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = hsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              bin_valid,
  output logic                              bin_stall,
  input  hsc_pkg::bin_item_t                bin_item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output hsc_pkg::result_item_t             result_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  hsc_pkg::cfg_t cfg;
  hsc_pkg::cmd_t cmd;
  hsc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;
  assign bin_stall = !cmd.load_open;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_begin      <= 12'd0;
      cfg.range_end        <= 13'd4096;
      cfg.search_origin    <= 12'd0;
      cfg.origin_from_mean <= 1'b1;
      cfg.run_length       <= 12'd8;
      cfg.bin_threshold    <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (hsc_pkg::cfg_idx_t'(cfg_index))
        hsc_pkg::CFG_RANGE_BEGIN:      cfg.range_begin      <= cfg_data[11:0];
        hsc_pkg::CFG_RANGE_END:        cfg.range_end        <= cfg_data[12:0];
        hsc_pkg::CFG_SEARCH_ORIGIN:    cfg.search_origin    <= cfg_data[11:0];
        hsc_pkg::CFG_ORIGIN_FROM_MEAN: cfg.origin_from_mean <= cfg_data[0];
        hsc_pkg::CFG_RUN_LENGTH:       cfg.run_length       <= cfg_data[11:0];
        hsc_pkg::CFG_BIN_THRESHOLD:    cfg.bin_threshold    <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  hsc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  hsc_dp #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .bin_valid    (bin_valid),
    .bin_item     (bin_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// File: rtl/hsc_div.sv
// ---------------------------------------------------------------------------
// hsc_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ---------------------------------------------------------------------------
module hsc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hsc_pkg::DIV_NUM_W-1:0]   num,
  input  logic [hsc_pkg::DIV_DEN_W-1:0]   den,
  input  logic [hsc_pkg::DIV_Q_W-1:0]     cap,
  output logic                            done,
  output logic [hsc_pkg::DIV_Q_W-1:0]     quo
);
  localparam int STEP_W = $clog2(hsc_pkg::DIV_NUM_W + 1);

  logic                            busy;
  logic [STEP_W-1:0]               step;
  logic [hsc_pkg::DIV_NUM_W-1:0]   numr;
  logic [hsc_pkg::DIV_DEN_W-1:0]   rem;
  logic [hsc_pkg::DIV_Q_W-1:0]     q;
  logic                            sat;
  logic [hsc_pkg::DIV_DEN_W:0]     rem_sh;
  logic                            qb;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, numr[hsc_pkg::DIV_NUM_W-1]};
    qb     = (rem_sh >= {1'b0, den});
  end

  // iterate one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        numr <= num;
        rem  <= '0;
        q    <= '0;
        sat  <= 1'b0;
        step <= STEP_W'(hsc_pkg::DIV_NUM_W);
      end else if (busy) begin
        rem  <= qb ? hsc_pkg::DIV_DEN_W'(rem_sh - {1'b0, den})
                   : hsc_pkg::DIV_DEN_W'(rem_sh);
        numr <= {numr[hsc_pkg::DIV_NUM_W-2:0], 1'b0};
        q    <= {q[hsc_pkg::DIV_Q_W-2:0], qb};
        sat  <= sat | q[hsc_pkg::DIV_Q_W-1];
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp to the cap
  assign quo = (sat || (q > cap)) ? cap : q;

endmodule

// File: rtl/hsc_ctrl.sv
// ---------------------------------------------------------------------------
// hsc_ctrl
// Sequencer: load, statistics passes, divisions, cutoff searches, result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  hsc_pkg::sts_t sts,
  output hsc_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_LOAD, S_STAT, S_MDIV, S_VAR, S_VDIV, S_DOWN, S_UP, S_OUT, S_DONE
  } state_t;

  state_t state;

  // hold state and registered commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      cmd           <= '0;
      cmd.load_open <= 1'b1;
    end else begin
      cmd.op_start  <= 1'b0;
      cmd.div_start <= 1'b0;
      cmd.out_load  <= 1'b0;
      cmd.clear     <= 1'b0;
      case (state)
        S_LOAD: begin
          if (sts.last_in) begin
            cmd.load_open <= 1'b0;
            cmd.op_start  <= 1'b1;
            cmd.op        <= hsc_pkg::OP_STAT;
            state         <= S_STAT;
          end
        end
        S_STAT: begin
          if (sts.op_done) begin
            if (sts.empty) begin
              cmd.op_start <= 1'b1;
              cmd.op       <= hsc_pkg::OP_DOWN;
              state        <= S_DOWN;
            end else begin
              cmd.div_start <= 1'b1;
              cmd.div_var   <= 1'b0;
              state         <= S_MDIV;
            end
          end
        end
        S_MDIV: begin
          if (sts.div_done) begin
            cmd.op_start <= 1'b1;
            cmd.op       <= hsc_pkg::OP_VAR;
            state        <= S_VAR;
          end
        end
        S_VAR: begin
          if (sts.op_done) begin
            cmd.div_start <= 1'b1;
            cmd.div_var   <= 1'b1;
            state         <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (sts.div_done) begin
            cmd.op_start <= 1'b1;
            cmd.op       <= hsc_pkg::OP_DOWN;
            state        <= S_DOWN;
          end
        end
        S_DOWN: begin
          if (sts.op_done) begin
            cmd.op_start <= 1'b1;
            cmd.op       <= hsc_pkg::OP_UP;
            state        <= S_UP;
          end
        end
        S_UP: begin
          if (sts.op_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            cmd.out_load <= 1'b1;
            cmd.clear    <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          cmd.load_open <= 1'b1;
          state         <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `HSC_ASSERT(a_open_only_loading, clk, rst, (state == S_LOAD) == cmd.load_open)
  `HSC_ASSERT(a_start_when_idle, clk, rst, cmd.op_start |-> !sts.busy)
  `HSC_ASSERT(a_done_single, clk, rst, sts.op_done |=> !sts.op_done)

endmodule

// File: rtl/hsc_dp.sv
// ---------------------------------------------------------------------------
// hsc_dp
// Bin store, sweep pipeline, accumulators, searches and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsc_dp #(
  parameter int BIN_COUNT   = hsc_pkg::BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = hsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hsc_pkg::cfg_t        cfg,
  input  hsc_pkg::cmd_t        cmd,
  output hsc_pkg::sts_t        sts,
  input  logic                 bin_valid,
  input  hsc_pkg::bin_item_t   bin_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output hsc_pkg::result_item_t result_item
);
  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int POS_W = $clog2(BIN_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BIN_COUNT - 1);
  localparam int ORG_W = hsc_pkg::ORG_W;

  // bin store, valid below the fill count
  logic [COUNT_WIDTH-1:0] bin_mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [POS_W-1:0]       load_pos;
  logic [15:0]            strip;
  logic                   bin_fire;

  // sweep control
  logic                   busy;
  hsc_pkg::op_t           op;
  logic                   issuing;
  logic [IDX_W-1:0]       addr;
  logic [IDX_W-1:0]       end_addr;
  logic                   dir_down;
  logic                   s1_valid, s1_zero;
  logic [IDX_W-1:0]       s1_idx;
  logic                   s2_valid, s3_valid;
  logic [31:0]                s2_cnt;
  logic [hsc_pkg::SQ_W-1:0]   s2_opnd;
  logic [hsc_pkg::MUL1_W-1:0] s3_plo, s3_phi;
  logic                   op_done;

  // accumulators and results
  logic [hsc_pkg::CNT_ACC_W-1:0] cnt_acc;
  logic [hsc_pkg::SUM_W-1:0]     sum_acc;
  logic [hsc_pkg::ACC_W-1:0]     var_acc;
  logic [19:0]                   mean;
  logic [30:0]                   var_q;
  logic [11:0]                   run;
  logic                          srch_found;
  logic [IDX_W-1:0]              lo_cut, hi_end;
  logic                          lo_found, hi_found;

  // derived combinational values
  logic [ORG_W-1:0]           b17, e17, org17, n17, he17, before17;
  logic                       range_ok;
  logic [IDX_W-1:0]           origin;
  logic [11:0]                n;
  logic [31:0]                c32;
  logic [hsc_pkg::DEV_W-1:0]  pos, mean24, dev;
  logic [hsc_pkg::SQ_W-1:0]   opnd;
  logic                       low;
  logic [12:0]                run_n;

  // divider
  logic [hsc_pkg::DIV_NUM_W-1:0] div_num;
  logic [hsc_pkg::DIV_DEN_W-1:0] div_den;
  logic [hsc_pkg::DIV_Q_W-1:0]   div_cap, div_quo;
  logic                          div_done;

  assign bin_fire = bin_valid & cmd.load_open;

  always_comb begin
    b17      = ORG_W'(cfg.range_begin);
    e17      = (ORG_W'(cfg.range_end) > ORG_W'(BIN_COUNT)) ? ORG_W'(BIN_COUNT)
                                                          : ORG_W'(cfg.range_end);
    range_ok = b17 < e17;
    org17    = cfg.origin_from_mean ? ORG_W'(mean[19:8]) : ORG_W'(cfg.search_origin);
    origin   = (org17 > ORG_W'(BIN_COUNT - 1)) ? LAST_BIN : IDX_W'(org17);
    n        = (cfg.run_length == 12'd0) ? 12'd1 : cfg.run_length;
    n17      = ORG_W'(n);
    he17     = ORG_W'(hi_end);
    before17 = (he17 >= n17) ? (he17 - n17) : '0;
    c32      = s1_zero ? 32'd0 : 32'(rd_data);
    pos      = hsc_pkg::DEV_W'(s1_idx) << 8;
    mean24   = hsc_pkg::DEV_W'(mean);
    dev      = (pos >= mean24) ? (pos - mean24) : (mean24 - pos);
    opnd     = (op == hsc_pkg::OP_VAR) ? (hsc_pkg::SQ_W'(dev) * hsc_pkg::SQ_W'(dev))
                                       : hsc_pkg::SQ_W'(s1_idx);
    low      = c32 < cfg.bin_threshold;
    run_n    = low ? ({1'b0, run} + 13'd1) : 13'd0;
    op_done  = busy && !issuing && !s1_valid && !s2_valid && !s3_valid && !cmd.op_start;
    div_num  = cmd.div_var ? hsc_pkg::DIV_NUM_W'(var_acc)
                           : hsc_pkg::DIV_NUM_W'({sum_acc, 8'h00});
    div_den  = cmd.div_var ? hsc_pkg::DIV_DEN_W'({cnt_acc, 8'h00})
                           : hsc_pkg::DIV_DEN_W'(cnt_acc);
    div_cap  = cmd.div_var ? hsc_pkg::VAR_CAP : hsc_pkg::MEAN_CAP;
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (bin_fire && (load_pos < POS_W'(BIN_COUNT))) begin
      bin_mem[IDX_W'(load_pos)] <= bin_item.bin_count[COUNT_WIDTH-1:0];
    end
    if (issuing) begin
      rd_data <= bin_mem[addr];
    end
  end

  // load side: fill count and channel latch
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      strip    <= '0;
    end else if (cmd.clear) begin
      load_pos <= '0;
    end else if (bin_fire) begin
      if (load_pos == '0) begin
        strip <= bin_item.strip_number;
      end
      if (load_pos < POS_W'(BIN_COUNT)) begin
        load_pos <= load_pos + POS_W'(1);
      end
    end
  end

  // sweep engine and pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      issuing  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      op       <= hsc_pkg::OP_STAT;
    end else begin
      // issue reads
      s1_valid <= issuing;
      s1_idx   <= addr;
      s1_zero  <= ({1'b0, addr} >= POS_W'(load_pos));
      if (issuing) begin
        addr <= dir_down ? (addr - IDX_W'(1)) : (addr + IDX_W'(1));
        if (addr == end_addr) begin
          issuing <= 1'b0;
        end
      end

      // stage one: count, index or squared deviation, search step
      s2_valid <= 1'b0;
      if (s1_valid) begin
        case (op)
          hsc_pkg::OP_STAT, hsc_pkg::OP_VAR: begin
            if (op == hsc_pkg::OP_STAT) begin
              cnt_acc <= cnt_acc + hsc_pkg::CNT_ACC_W'(c32);
            end
            s2_valid <= 1'b1;
            s2_cnt   <= c32;
            s2_opnd  <= opnd;
          end
          hsc_pkg::OP_DOWN, hsc_pkg::OP_UP: begin
            if (!srch_found) begin
              run <= run_n[11:0];
              if (run_n >= {1'b0, n}) begin
                srch_found <= 1'b1;
                issuing    <= 1'b0;
                if (op == hsc_pkg::OP_DOWN) begin
                  lo_found <= 1'b1;
                  lo_cut   <= s1_idx;
                end else begin
                  hi_found <= 1'b1;
                  hi_end   <= s1_idx;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      // stage two: count times the low and high halves of the operand
      s3_valid <= s2_valid;
      s3_plo   <= hsc_pkg::MUL1_W'(s2_cnt)
                  * hsc_pkg::MUL1_W'(s2_opnd[hsc_pkg::DEV_W-1:0]);
      s3_phi   <= hsc_pkg::MUL1_W'(s2_cnt)
                  * hsc_pkg::MUL1_W'(s2_opnd[hsc_pkg::SQ_W-1:hsc_pkg::DEV_W]);

      // stage three: accumulate
      if (s3_valid) begin
        if (op == hsc_pkg::OP_VAR) begin
          var_acc <= var_acc + hsc_pkg::ACC_W'(s3_plo)
                     + (hsc_pkg::ACC_W'(s3_phi) << hsc_pkg::DEV_W);
        end else begin
          sum_acc <= sum_acc + hsc_pkg::SUM_W'(s3_plo);
        end
      end

      if (op_done) begin
        busy <= 1'b0;
      end

      // start a pass or a search
      if (cmd.op_start) begin
        busy       <= 1'b1;
        op         <= cmd.op;
        run        <= '0;
        srch_found <= 1'b0;
        case (cmd.op)
          hsc_pkg::OP_STAT: begin
            addr     <= IDX_W'(b17);
            end_addr <= IDX_W'(e17 - ORG_W'(1));
            dir_down <= 1'b0;
            issuing  <= range_ok;
            cnt_acc  <= '0;
            sum_acc  <= '0;
            mean     <= '0;
            var_q    <= '0;
          end
          hsc_pkg::OP_VAR: begin
            addr     <= IDX_W'(b17);
            end_addr <= IDX_W'(e17 - ORG_W'(1));
            dir_down <= 1'b0;
            issuing  <= range_ok;
            var_acc  <= '0;
          end
          hsc_pkg::OP_DOWN: begin
            addr     <= origin;
            end_addr <= '0;
            dir_down <= 1'b1;
            issuing  <= 1'b1;
            lo_found <= 1'b0;
            lo_cut   <= '0;
          end
          hsc_pkg::OP_UP: begin
            addr     <= origin;
            end_addr <= LAST_BIN;
            dir_down <= 1'b0;
            issuing  <= 1'b1;
            hi_found <= 1'b0;
            hi_end   <= LAST_BIN;
          end
          default: begin
          end
        endcase
      end

      // take the quotient
      if (div_done) begin
        if (cmd.div_var) begin
          var_q <= div_quo[30:0];
        end else begin
          mean  <= div_quo[19:0];
        end
      end
    end
  end

  hsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .cap   (div_cap),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        result_valid                    <= 1'b1;
        result_item.strip_id_out        <= strip;
        result_item.total_count         <= cnt_acc[43:0];
        result_item.weighted_sum        <= sum_acc[55:0];
        result_item.mean_value          <= mean;
        result_item.variance_value      <= var_q;
        result_item.empty_flag          <= (cnt_acc == '0);
        result_item.lower_cutoff        <= 12'(lo_cut);
        result_item.upper_cutoff_end    <= 12'(hi_end);
        result_item.upper_cutoff_before <= before17[11:0];
        result_item.lower_found         <= lo_found;
        result_item.upper_found         <= hi_found;
      end
    end
  end

  always_comb begin
    sts.last_in  = bin_fire & bin_item.is_last;
    sts.op_done  = op_done;
    sts.div_done = div_done;
    sts.empty    = (cnt_acc == '0);
    sts.out_free = !result_valid || !result_stall;
    sts.busy     = busy;
  end

  `HSC_ASSERT(a_fill_bound, clk, rst, load_pos <= POS_W'(BIN_COUNT))
  `HSC_ASSERT(a_out_free, clk, rst, cmd.out_load |-> !(result_valid && result_stall))
  `HSC_ASSERT(a_start_busy, clk, rst, cmd.op_start |=> busy)

endmodule
